// ----- rtl/gps_pkg.sv -----
// Package for the genetic-algorithm parent selector.
// Holds sizes, field widths, codes and the controller/datapath interface structs.
// No dependencies.
package gps_pkg;

   localparam int ENTRY_COUNT = 256;
   localparam int IDX_W = 8;
   localparam int WEIGHT_W = 16;
   localparam int FIT_W = 32;
   localparam int DRAW_W = 16;
   localparam int SUM_W = 24;
   localparam int CNT_W = 5;
   localparam int MODE_W = 2;
   localparam int KIND_W = 2;
   localparam int REQ_DATA_W = 72;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [MODE_W-1:0] MODE_REPL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NO_REPL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TOURN = 2'd2;

   localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DRAW = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TSIZE = 2'd1;

   typedef struct packed {
      logic load;
      logic clear;
      logic wipe_step;
      logic scan_start;
      logic scan_step;
      logic tour_start;
      logic tour_update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_clear;
      logic is_draw;
      logic is_cand;
      logic wipe_done;
      logic scan_hit;
      logic tour_done;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/gps_ctrl.sv -----
// Controller state machine of the parent selector.
// Sequences loads, roulette scans, tournament updates and result hand-off; uses gps_pkg.
module gps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  gps_pkg::status_type status,
   output gps_pkg::cmd_type    cmd
);
   import gps_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_TCMP = 3'd2;
   localparam logic [2:0] S_EMIT = 3'd3;
   localparam logic [2:0] S_WIPE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = status.is_load;
               cmd.clear = status.is_clear;
               if (status.is_clear) begin
                  state_in = S_WIPE;
               end else if (status.is_draw) begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end else if (status.is_cand) begin
                  cmd.tour_start = 1'b1;
                  state_in = S_TCMP;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               state_in = S_EMIT;
            end
         end
         S_TCMP: begin
            cmd.tour_update = 1'b1;
            state_in = status.tour_done ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/gps_datapath.sv -----
// Datapath of the parent selector: weight and fitness memories, running sum,
// chosen flags, tournament best, configuration registers and result register; uses gps_pkg.
module gps_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [gps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [gps_pkg::KIND_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gps_pkg::IDX_W-1:0]        rsp_tdata,
   output logic [0:0]                       rsp_tuser,
   input  logic                             csr_we,
   input  logic [gps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  gps_pkg::cmd_type                 cmd,
   output gps_pkg::status_type              status
);
   import gps_pkg::*;

   logic [IDX_W-1:0]    req_index;
   logic [WEIGHT_W-1:0] req_weight;
   logic [FIT_W-1:0]    req_fitness;
   logic [DRAW_W-1:0]   req_draw;
   logic                in_range;

   logic [WEIGHT_W-1:0] weight_mem [ENTRY_COUNT];
   logic [FIT_W-1:0]    fitness_mem [ENTRY_COUNT];
   logic [WEIGHT_W-1:0] weight_rd_ff;
   logic [FIT_W-1:0]    fitness_rd_ff;
   logic [IDX_W-1:0]    weight_addr;

   logic [MODE_W-1:0]   mode_ff;
   logic [CNT_W-1:0]    tsize_ff;

   logic [IDX_W-1:0]    scan_idx_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [DRAW_W-1:0]   draw_ff;
   logic [IDX_W-1:0]    sel_ff;

   logic                chosen_mem [ENTRY_COUNT];
   logic                chosen_rd_ff;
   logic [IDX_W-1:0]    wipe_idx_ff;
   logic [FIT_W-1:0]    best_fit_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IDX_W-1:0]    cand_ff;
   logic                take;
   logic [IDX_W-1:0]    new_idx;
   logic [CNT_W-1:0]    count_in;
   logic [CNT_W-1:0]    size_eff;

   logic                rsp_valid_ff;
   logic [IDX_W-1:0]    rsp_idx_ff;
   logic                rsp_rej_ff;
   logic                reject;

   assign req_index = req_tdata[7:0];
   assign req_weight = req_tdata[23:8];
   assign req_fitness = req_tdata[55:24];
   assign req_draw = req_tdata[71:56];
   assign in_range = int'(req_index) < ENTRY_COUNT;

   assign status.is_load = (req_tuser == KIND_LOAD);
   assign status.is_clear = (req_tuser == KIND_CLEAR);
   assign status.is_draw = (req_tuser == KIND_DRAW)
                           && (mode_ff == MODE_REPL || mode_ff == MODE_NO_REPL);
   assign status.is_cand = (req_tuser == KIND_DRAW) && (mode_ff == MODE_TOURN) && in_range;

   // Memories: one write port for loads, one registered read port each.
   assign weight_addr = cmd.scan_start ? '0 : scan_idx_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load && in_range) begin
         weight_mem[req_index] <= req_weight;
         fitness_mem[req_index] <= req_fitness;
      end
      weight_rd_ff <= weight_mem[weight_addr];
      fitness_rd_ff <= fitness_mem[req_index];
   end

   // Roulette scan: read data of entry scan_idx_ff arrives in the cycle after its address.
   assign sum_in = sum_ff + SUM_W'(weight_rd_ff);
   assign status.scan_hit = (sum_in >= SUM_W'(draw_ff))
                            || (scan_idx_ff == IDX_W'(ENTRY_COUNT - 1));

   // Tournament compare against the running best.
   assign take = (count_ff == '0) || (fitness_rd_ff < best_fit_ff);
   assign new_idx = take ? cand_ff : best_idx_ff;
   assign count_in = count_ff + CNT_W'(1);
   assign size_eff = (tsize_ff == '0) ? CNT_W'(1) : tsize_ff;
   assign status.tour_done = (count_in >= size_eff);

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
         sum_ff <= '0;
         draw_ff <= req_draw;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         sum_ff <= sum_in;
      end
      if (cmd.scan_step && status.scan_hit) begin
         sel_ff <= scan_idx_ff;
      end else if (cmd.tour_update && status.tour_done) begin
         sel_ff <= new_idx;
      end
      if (cmd.tour_start) begin
         cand_ff <= req_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         best_fit_ff <= '1;
         best_idx_ff <= '0;
         count_ff <= '0;
      end else if (cmd.tour_update) begin
         if (status.tour_done) begin
            best_fit_ff <= '1;
            best_idx_ff <= '0;
            count_ff <= '0;
         end else begin
            if (take) begin
               best_fit_ff <= fitness_rd_ff;
            end
            best_idx_ff <= new_idx;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_REPL;
         tsize_ff <= CNT_W'(2);
      end else if (csr_we) begin
         if (csr_index == CSR_MODE) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end else if (csr_index == CSR_TSIZE) begin
            tsize_ff <= csr_wdata[CNT_W-1:0];
         end
      end
   end

   // Chosen flags live in a memory that is wiped one entry per cycle after reset or clear.
   // The flag of the scanned entry is read along the scan, so the hit entry's flag is held.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         wipe_idx_ff <= '0;
      end else if (cmd.wipe_step) begin
         wipe_idx_ff <= wipe_idx_ff + IDX_W'(1);
      end
   end

   assign status.wipe_done = (wipe_idx_ff == IDX_W'(ENTRY_COUNT - 1));

   always_ff @(posedge clock) begin
      if (cmd.wipe_step) begin
         chosen_mem[wipe_idx_ff] <= 1'b0;
      end else if (cmd.emit && mode_ff == MODE_NO_REPL && !reject) begin
         chosen_mem[sel_ff] <= 1'b1;
      end
      if (cmd.scan_step) begin
         chosen_rd_ff <= chosen_mem[scan_idx_ff];
      end
   end

   // Result register.
   assign reject = (mode_ff == MODE_NO_REPL) && chosen_rd_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_idx_ff <= reject ? '0 : sel_ff;
         rsp_rej_ff <= reject;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_idx_ff;
   assign rsp_tuser = rsp_rej_ff;

endmodule

// ----- rtl/ga_parent_selection.sv -----
// Top level of the genetic-algorithm parent selector.
// Joins gps_ctrl and gps_datapath; uses gps_pkg.
//
// Requests arrive on req_ (tuser = kind; tdata = index, weight, fitness, random_value
// from the lowest bit up). Results leave on rsp_ (tdata = parent_index,
// tuser = rejected). Registers mode (index 0) and tournament size (index 1) are
// written through csr_we, csr_index and csr_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce.
// A load request gives no result and leaves the block idle. A clear request wipes the
// chosen flags one entry per cycle, and the next request is taken once the wipe is
// done. A proportional draw scans the weights one entry per cycle, registers the
// result once the result register is free, and takes the next request after that.
// A tournament candidate passes through a registered fitness read and a compare;
// the last one of a tournament then goes through the emit state to register the result.
// One result register sits on rsp_: while the receiver stalls it holds its
// result and the block keeps taking requests until a second result is ready,
// which then waits inside until the register frees.
// Synchronous reset empties the result register, sets mode to 0 and the tournament
// size to 2 and clears the tournament state; the chosen flags are then wiped with
// req_tready low. Stored weights and fitness values are undefined until loaded.
module ga_parent_selection (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [gps_pkg::REQ_DATA_W-1:0] req_tdata,  // index, weight, fitness, random_value
   input  logic [gps_pkg::KIND_W-1:0]     req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [gps_pkg::IDX_W-1:0]      rsp_tdata,  // parent_index
   output logic [0:0]                     rsp_tuser,  // rejected
   input  logic                           csr_we,
   input  logic [gps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gps_pkg::*;

   cmd_type    cmd;
   status_type status;

   gps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gps_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- rtl/gps_checker.sv -----
// Port-level checker for the parent selector, bound to the top level.
// Uses gps_pkg for widths and codes.
module gps_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [gps_pkg::KIND_W-1:0]     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gps_pkg::IDX_W-1:0]      rsp_tdata,
   input logic [0:0]                     rsp_tuser
);
   import gps_pkg::*;

   logic req_fast;

   assign req_fast = req_tvalid && req_tready && (req_tuser == KIND_LOAD);

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("rejected result with nonzero index");

   assert property (@(posedge clock) disable iff (reset)
      req_fast |=> req_tready)
      else $error("load request did not finish in one cycle");

   assert property (@(posedge clock) disable iff (reset)
      req_fast && !rsp_tvalid |=> !rsp_tvalid)
      else $error("load request produced a result");

endmodule

bind ga_parent_selection gps_checker u_gps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- test/ga_parent_selection_tb.sv -----
`timescale 1ns / 1ps
// Testbench for ga_parent_selection: loads a population, then checks roulette draws with and
// without replacement and tournaments under several register settings against an in-bench model.
// Depends on gps_pkg and the ga_parent_selection RTL.
module ga_parent_selection_tb;
   import gps_pkg::*;

   localparam int IDLE_PCT = 8;
   localparam int SETTLE_CYCLES = ENTRY_COUNT + 16;
   localparam int STALL_LIMIT = 4000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [FIT_W-1:0] FIT_WORST = '1;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [IDX_W-1:0]    index;
      logic [WEIGHT_W-1:0] weight;
      logic [FIT_W-1:0]    fitness;
      logic [DRAW_W-1:0]   draw;
      bit                  drain_first;
   } sel_req_type;

   typedef struct {
      logic [IDX_W-1:0] parent;
      logic             rejected;
   } parent_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [IDX_W-1:0]      rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ga_parent_selection dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   sel_req_type req_backlog[$];
   sel_req_type req_now;
   parent_type  expected_parents[$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;

   logic [WEIGHT_W-1:0] weight_mem [ENTRY_COUNT];
   logic [FIT_W-1:0]    fitness_mem [ENTRY_COUNT];
   bit                  taken [ENTRY_COUNT];
   logic [FIT_W-1:0]    best_fit;
   logic [IDX_W-1:0]    best_idx;
   logic [CNT_W-1:0]    cand_count;
   logic [MODE_W-1:0]   cur_mode;
   logic [CNT_W-1:0]    cur_tsize;

   function automatic void clear_round();
      foreach (taken[i]) taken[i] = 1'b0;
      best_fit = FIT_WORST;
      best_idx = '0;
      cand_count = '0;
   endfunction

   function automatic logic [IDX_W-1:0] roulette_pick(input logic [DRAW_W-1:0] draw);
      logic [SUM_W-1:0] run_sum;
      run_sum = '0;
      for (int c = 0; c < ENTRY_COUNT; c++) begin
         run_sum = run_sum + SUM_W'(weight_mem[c]);
         if (run_sum >= SUM_W'(draw)) return IDX_W'(c);
      end
      return IDX_W'(ENTRY_COUNT - 1);
   endfunction

   function automatic void predict_selection(input sel_req_type r);
      logic [IDX_W-1:0] pick;
      logic [CNT_W-1:0] tsz;
      case (r.kind)
         KIND_LOAD: begin
            weight_mem[r.index] = r.weight;
            fitness_mem[r.index] = r.fitness;
         end
         KIND_CLEAR: begin
            clear_round();
         end
         KIND_DRAW: begin
            if (cur_mode == MODE_REPL || cur_mode == MODE_NO_REPL) begin
               pick = roulette_pick(r.draw);
               if (cur_mode == MODE_NO_REPL && taken[pick]) begin
                  expected_parents.push_back(parent_type'{'0, 1'b1});
               end else begin
                  if (cur_mode == MODE_NO_REPL) taken[pick] = 1'b1;
                  expected_parents.push_back(parent_type'{pick, 1'b0});
               end
            end else if (cur_mode == MODE_TOURN) begin
               tsz = (cur_tsize == '0) ? CNT_W'(1) : cur_tsize;
               if (cand_count == '0 || fitness_mem[r.index] < best_fit) begin
                  best_fit = fitness_mem[r.index];
                  best_idx = r.index;
               end
               cand_count = cand_count + CNT_W'(1);
               if (cand_count >= tsz) begin
                  expected_parents.push_back(parent_type'{best_idx, 1'b0});
                  best_fit = FIT_WORST;
                  best_idx = '0;
                  cand_count = '0;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void add_req(input logic [KIND_W-1:0] kind, input int index,
         input int unsigned weight, input logic [FIT_W-1:0] fitness,
         input int unsigned draw, input bit drain_first = 1'b0);
      sel_req_type r;
      r.kind = kind;
      r.index = IDX_W'(index);
      r.weight = WEIGHT_W'(weight);
      r.fitness = fitness;
      r.draw = DRAW_W'(draw);
      r.drain_first = drain_first;
      req_backlog.push_back(r);
   endfunction

   function automatic sel_req_type rand_req();
      sel_req_type r;
      int roll;
      roll = $urandom_range(99);
      r.index = IDX_W'($urandom);
      r.weight = WEIGHT_W'($urandom);
      r.fitness = $urandom;
      r.draw = DRAW_W'($urandom);
      r.drain_first = ($urandom_range(49) == 0);
      if (roll < 12) begin
         r.kind = KIND_LOAD;
         if ($urandom_range(9) != 0) r.weight = WEIGHT_W'($urandom_range(255));
         if ($urandom_range(2) == 0) r.fitness = $urandom_range(7);
      end else if (roll < 16) begin
         r.kind = KIND_CLEAR;
      end else if (roll < 19) begin
         r.kind = KIND_SPARE;
      end else begin
         r.kind = KIND_DRAW;
         if ($urandom_range(9) < 7) r.draw = DRAW_W'($urandom_range(32767));
      end
      return r;
   endfunction

   task automatic add_random(input int count);
      repeat (count) req_backlog.push_back(rand_req());
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_tvalid || expected_parents.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_MODE) cur_mode = val[MODE_W-1:0];
      else if (idx == CSR_TSIZE) cur_tsize = val[CNT_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_selection(req_now);
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0
                  && !(req_backlog[0].drain_first && expected_parents.size() != 0)
                  && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_now = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {req_now.draw, req_now.fitness, req_now.weight, req_now.index};
               req_tuser <= req_now.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      parent_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_parents.size() == 0) begin
               $display("%0t: unexpected result, parent_index %0d rejected %0d",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = expected_parents.pop_front();
               if (rsp_tdata !== want.parent) begin
                  $display("%0t: parent_index expected %0d actual %0d",
                           $time, want.parent, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== want.rejected) begin
                  $display("%0t: rejected expected %0d actual %0d",
                           $time, want.rejected, rsp_tuser[0]);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int n;
      cur_mode = MODE_REPL;
      cur_tsize = CNT_W'(2);
      clear_round();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every entry is loaded before anything reads the stores.
      for (n = 0; n < ENTRY_COUNT; n++) begin
         if (n == 1)
            add_req(KIND_LOAD, n, 'hFFFF, '0, $urandom);
         else if (n == 0 || n == 2)
            add_req(KIND_LOAD, n, 0, FIT_WORST, $urandom);
         else
            add_req(KIND_LOAD, n, $urandom_range(255),
                    ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom, $urandom);
      end

      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 0);
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 'hFFFF);
      add_req(KIND_LOAD, 1, 0, '0, $urandom);
      // With entry 1 at weight zero, a full-scale draw runs past the total weight.
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 'hFFFF, 1'b1);
      add_req(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
      add_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      settle();
      quiet = 1'b1;
      add_random(120);
      settle();
      quiet = 1'b0;

      write_csr(CSR_MODE, {3'b111, MODE_NO_REPL});
      write_csr(CSR_SPARE_A, 5'h1F);
      write_csr(CSR_SPARE_B, 5'h0A);
      add_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 0);
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 0);
      add_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, 0);
      add_random(150);
      settle();

      write_csr(CSR_MODE, {3'b101, MODE_TOURN});
      write_csr(CSR_TSIZE, 5'd0);
      add_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, 5, $urandom, $urandom, $urandom);
      add_random(10);
      settle();

      write_csr(CSR_TSIZE, 5'd2);
      add_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom);
      add_req(KIND_LOAD, 0, $urandom_range(255), FIT_WORST, $urandom);
      add_req(KIND_LOAD, 2, $urandom_range(255), FIT_WORST, $urandom);
      add_req(KIND_LOAD, 1, $urandom_range(255), '0, $urandom);
      // A tie keeps the earlier candidate, even at the worst possible fitness.
      add_req(KIND_DRAW, 0, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, 2, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, 2, $urandom, $urandom, $urandom);
      add_req(KIND_DRAW, 1, $urandom, $urandom, $urandom);
      add_random(60);
      settle();

      write_csr(CSR_TSIZE, 5'd31);
      add_random(60);
      settle();

      write_csr(CSR_TSIZE, 5'd16);
      add_random(50);
      settle();

      write_csr(CSR_TSIZE, CSR_DATA_W'($urandom_range(3, 15)));
      add_random(40);
      settle();

      write_csr(CSR_TSIZE, 5'd1);
      add_random(15);
      settle();

      write_csr(CSR_MODE, CSR_DATA_W'(MODE_UNUSED));
      add_req(KIND_DRAW, $urandom, $urandom, $urandom, $urandom);
      add_random(20);
      settle();

      write_csr(CSR_MODE, CSR_DATA_W'(MODE_NO_REPL));
      add_random(40);
      settle();

      write_csr(CSR_MODE, CSR_DATA_W'(MODE_REPL));
      add_random(40);
      settle();

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gps_pkg.sv
rtl/gps_ctrl.sv
rtl/gps_datapath.sv
rtl/ga_parent_selection.sv
rtl/gps_checker.sv
test/ga_parent_selection_tb.sv
